@@ hw/rtl/kts_pkg.sv @@
// Shared types and constants for the topological sort block.
// Holds item structs, command codes, sequencer states and size defaults.
// No dependencies.
package kts_pkg;

  localparam int unsigned KTS_MAX_NODES = 32;
  localparam int unsigned KTS_MAX_EDGES = 64;
  localparam int unsigned RESULT_CAP    = 32;
  localparam int unsigned NODE_W        = 5;
  localparam int unsigned TOTAL_W       = 6;

  typedef enum logic {
    CMD_ADD_EDGE = 1'b0,
    CMD_RUN      = 1'b1
  } kts_cmd_t;

  typedef struct packed {
    kts_cmd_t            command;
    logic [NODE_W-1:0]   producer_node;
    logic [NODE_W-1:0]   consumer_node;
    logic [TOTAL_W-1:0]  node_total;
  } kts_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] order_node;
    logic              has_node;
    logic              last;
    logic              incomplete;
    logic              edge_overflow;
  } kts_out_t;

  // Strobes from the sequencer to the graph store
  typedef struct packed {
    logic node_rd;  // read head, tail and list valid at node address
    logic deg_rd;   // read in-degree at degree address
    logic edge_rd;  // read consumer and next link at edge address
    logic add_wr;   // append one edge to the producer's list
    logic deg_wr;   // write in-degree at degree address
    logic clear;    // drop the whole graph
  } kts_store_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_EMIT,
    ST_HEAD,
    ST_DEG_RD,
    ST_DEG_UPD,
    ST_DONE
  } kts_state_t;

endpackage

@@ hw/rtl/kts_store.sv @@
// Graph store: per-node list head/tail and in-degree, per-edge consumer and link.
// Uses kts_pkg for the control struct and size defaults.
module kts_store import kts_pkg::*; #(
  parameter int unsigned MAX_NODES = KTS_MAX_NODES,
  parameter int unsigned MAX_EDGES = KTS_MAX_EDGES,
  localparam int unsigned NW = $clog2(MAX_NODES),
  localparam int unsigned EW = $clog2(MAX_EDGES),
  localparam int unsigned FW = $clog2(MAX_EDGES + 1),
  localparam int unsigned DW = $clog2(MAX_EDGES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  kts_store_ctl_t ctl,
  input  logic [NW-1:0]  node_addr,
  input  logic [NW-1:0]  deg_addr,
  input  logic [EW-1:0]  edge_addr,
  input  logic [DW-1:0]  deg_wdata,
  output logic [EW-1:0]  head_val,
  output logic [EW-1:0]  tail_val,
  output logic           list_val,
  output logic [DW-1:0]  deg_val,
  output logic [NW-1:0]  cons_val,
  output logic [EW-1:0]  next_val,
  output logic           full
);

  logic [EW-1:0] head_mem [MAX_NODES];
  logic [EW-1:0] tail_mem [MAX_NODES];
  logic [DW-1:0] deg_mem  [MAX_NODES];
  logic [NW-1:0] cons_mem [MAX_EDGES];
  logic [EW-1:0] next_mem [MAX_EDGES];

  logic [MAX_NODES-1:0] list_vld_r, list_vld_nxt;
  logic [MAX_NODES-1:0] deg_vld_r, deg_vld_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [EW-1:0]        fill_idx;

  logic [EW-1:0] head_rd_r, tail_rd_r, next_rd_r;
  logic          list_vld_rd_r, deg_vld_rd_r;
  logic [DW-1:0] deg_rd_r;
  logic [NW-1:0] cons_rd_r;

  assign fill_idx = fill_r[EW-1:0];

  // Memories: one write and one registered read per array
  always_ff @(posedge clk) begin
    if (ctl.add_wr) begin
      cons_mem[fill_idx]  <= deg_addr;
      tail_mem[node_addr] <= fill_idx;
      if (list_vld_rd_r) begin
        next_mem[tail_rd_r] <= fill_idx;
      end else begin
        head_mem[node_addr] <= fill_idx;
      end
    end
    if (ctl.deg_wr) begin
      deg_mem[deg_addr] <= deg_wdata;
    end
    if (ctl.node_rd) begin
      head_rd_r     <= head_mem[node_addr];
      tail_rd_r     <= tail_mem[node_addr];
      list_vld_rd_r <= list_vld_r[node_addr];
    end
    if (ctl.deg_rd) begin
      deg_rd_r     <= deg_mem[deg_addr];
      deg_vld_rd_r <= deg_vld_r[deg_addr];
    end
    if (ctl.edge_rd) begin
      cons_rd_r <= cons_mem[edge_addr];
      next_rd_r <= next_mem[edge_addr];
    end
  end

  always_comb begin
    list_vld_nxt = list_vld_r;
    deg_vld_nxt  = deg_vld_r;
    fill_nxt     = fill_r;
    if (ctl.add_wr) begin
      list_vld_nxt[node_addr] = 1'b1;
      fill_nxt                = fill_r + FW'(1);
    end
    if (ctl.deg_wr) begin
      deg_vld_nxt[deg_addr] = 1'b1;
    end
    if (ctl.clear) begin
      list_vld_nxt = '0;
      deg_vld_nxt  = '0;
      fill_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_vld_r <= '0;
      deg_vld_r  <= '0;
      fill_r     <= '0;
    end else begin
      list_vld_r <= list_vld_nxt;
      deg_vld_r  <= deg_vld_nxt;
      fill_r     <= fill_nxt;
    end
  end

  assign head_val = head_rd_r;
  assign tail_val = tail_rd_r;
  assign list_val = list_vld_rd_r;
  assign deg_val  = deg_vld_rd_r ? deg_rd_r : '0;
  assign cons_val = cons_rd_r;
  assign next_val = next_rd_r;
  assign full     = (fill_r == FW'(MAX_EDGES));

endmodule

@@ hw/rtl/kts_fifo.sv @@
// Ready queue of nodes whose in-degree has dropped to zero.
// Uses kts_pkg for the default depth; memory with registered read.
module kts_fifo import kts_pkg::*; #(
  parameter int unsigned DEPTH = RESULT_CAP,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned PW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          push,
  input  logic [AW-1:0] push_data,
  input  logic          pop,
  output logic [AW-1:0] rd_data,
  output logic          empty
);

  logic [AW-1:0] mem [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r[AW-1:0]] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_r[AW-1:0]];
    end
  end

  always_comb begin
    wr_nxt = push ? wr_r + PW'(1) : wr_r;
    rd_nxt = pop  ? rd_r + PW'(1) : rd_r;
    if (clear) begin
      wr_nxt = '0;
      rd_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign empty   = (rd_r == wr_r);

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (32'(wr_r) < DEPTH))
    else $error("ready queue pushed past its depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("ready queue popped while empty");

endmodule

@@ hw/rtl/topological_sort_kahn_top.sv @@
// Topological sort (Kahn) engine: edge loads build per-node consumer lists, a run emits the order.
// Edge load: busy while the append is written (not when the edge is dropped), no result.
// Run: busy through the in-degree scan, then for each popped node its emit and the walk of its edges,
//   all through the single in-degree read/update unit; results trail their node by one pop.
// Results are one-cycle strobes on out_valid that the receiver cannot stall; the final one has last.
// Synchronous active-low reset empties the graph, as does every run. Uses kts_pkg, kts_store, kts_fifo.
module topological_sort_kahn_top import kts_pkg::*; #(
  parameter int unsigned MAX_NODES = KTS_MAX_NODES,
  parameter int unsigned MAX_EDGES = KTS_MAX_EDGES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  kts_in_t  in_item,
  output logic     out_valid,
  output kts_out_t out_item
);

  localparam int unsigned NW   = $clog2(MAX_NODES);
  localparam int unsigned EW   = $clog2(MAX_EDGES);
  localparam int unsigned DW   = $clog2(MAX_EDGES + 1);
  // Usable node count: bounded by both the store and the result count
  localparam int unsigned NCAP = (MAX_NODES < RESULT_CAP) ? MAX_NODES : RESULT_CAP;
  localparam int unsigned NCW  = $clog2(NCAP + 1);
  localparam int unsigned AW   = $clog2(NCAP);

  kts_state_t     state_r, state_nxt;
  kts_store_ctl_t ctl;

  logic [NW-1:0]  prod_r, prod_nxt, cons_r, cons_nxt;
  logic [NCW-1:0] n_r, n_nxt, scan_r, scan_nxt, emit_cnt_r, emit_cnt_nxt;
  logic [EW-1:0]  edge_r, edge_nxt, tail_r, tail_nxt;
  logic           ovf_r, ovf_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [AW-1:0]  pend_node_r, pend_node_nxt;
  logic           out_valid_r, out_valid_nxt;
  kts_out_t       out_item_r, out_item_nxt;

  logic [NW-1:0]  node_addr, deg_addr;
  logic [EW-1:0]  edge_addr;
  logic [DW-1:0]  deg_wdata, deg_val, deg_step;
  logic           deg_inc;
  logic [EW-1:0]  head_val, tail_val, next_val;
  logic           list_val, store_full;
  logic [NW-1:0]  cons_val;

  logic           fifo_push, fifo_pop, fifo_clear, fifo_empty;
  logic [AW-1:0]  fifo_push_data, fifo_rd_data;

  logic           in_ok;
  logic [NCW-1:0] total_sat;

  kts_store #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .node_addr (node_addr),
    .deg_addr  (deg_addr),
    .edge_addr (edge_addr),
    .deg_wdata (deg_wdata),
    .head_val  (head_val),
    .tail_val  (tail_val),
    .list_val  (list_val),
    .deg_val   (deg_val),
    .cons_val  (cons_val),
    .next_val  (next_val),
    .full      (store_full)
  );

  kts_fifo #(
    .DEPTH (NCAP)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (fifo_clear),
    .push      (fifo_push),
    .push_data (fifo_push_data),
    .pop       (fifo_pop),
    .rd_data   (fifo_rd_data),
    .empty     (fifo_empty)
  );

  // Shared in-degree unit: increment on edge load, decrement on edge walk
  assign deg_step = deg_inc ? deg_val + DW'(1) : deg_val - DW'(1);

  // Both endpoints must lie inside the node store; otherwise drop silently
  assign in_ok = (32'(in_item.producer_node) < MAX_NODES) &&
                 (32'(in_item.consumer_node) < MAX_NODES);

  assign total_sat = (32'(in_item.node_total) > NCAP) ? NCW'(NCAP)
                                                      : NCW'(in_item.node_total);

  always_comb begin
    state_nxt      = state_r;
    prod_nxt       = prod_r;
    cons_nxt       = cons_r;
    n_nxt          = n_r;
    scan_nxt       = scan_r;
    emit_cnt_nxt   = emit_cnt_r;
    edge_nxt       = edge_r;
    tail_nxt       = tail_r;
    ovf_nxt        = ovf_r;
    pend_v_nxt     = pend_v_r;
    pend_node_nxt  = pend_node_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;

    ctl            = '0;
    node_addr      = prod_r;
    deg_addr       = cons_r;
    edge_addr      = edge_r;
    deg_inc        = 1'b1;
    deg_wdata      = deg_step;
    fifo_push      = 1'b0;
    fifo_push_data = AW'(scan_r);
    fifo_pop       = 1'b0;
    fifo_clear     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.command == CMD_RUN) begin
            n_nxt        = total_sat;
            scan_nxt     = '0;
            emit_cnt_nxt = '0;
            state_nxt    = ST_SCAN_RD;
          end else if (in_ok) begin
            if (store_full) begin
              ovf_nxt = 1'b1;
            end else begin
              // Fetch the producer's tail and the consumer's count for the append
              prod_nxt    = NW'(in_item.producer_node);
              cons_nxt    = NW'(in_item.consumer_node);
              node_addr   = NW'(in_item.producer_node);
              deg_addr    = NW'(in_item.consumer_node);
              ctl.node_rd = 1'b1;
              ctl.deg_rd  = 1'b1;
              state_nxt   = ST_ADD;
            end
          end
        end
      end
      ST_ADD: begin
        ctl.add_wr = 1'b1;
        ctl.deg_wr = 1'b1;
        deg_inc    = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SCAN_RD: begin
        if (scan_r == n_r) begin
          state_nxt = ST_POP;
        end else begin
          deg_addr   = NW'(scan_r);
          ctl.deg_rd = 1'b1;
          state_nxt  = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        // Queue source nodes in index order
        if (deg_val == '0) begin
          fifo_push      = 1'b1;
          fifo_push_data = AW'(scan_r);
        end
        scan_nxt  = scan_r + NCW'(1);
        state_nxt = ST_SCAN_RD;
      end
      ST_POP: begin
        if (fifo_empty) begin
          state_nxt = ST_DONE;
        end else begin
          fifo_pop  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Release the previous node now that a later one exists; hold this one
        if (pend_v_r) begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.order_node      = NODE_W'(pend_node_r);
          out_item_nxt.has_node        = 1'b1;
          out_item_nxt.last            = 1'b0;
          out_item_nxt.incomplete      = 1'b0;
          out_item_nxt.edge_overflow   = 1'b0;
        end
        pend_v_nxt    = 1'b1;
        pend_node_nxt = fifo_rd_data;
        emit_cnt_nxt  = emit_cnt_r + NCW'(1);
        node_addr     = NW'(fifo_rd_data);
        ctl.node_rd   = 1'b1;
        state_nxt     = ST_HEAD;
      end
      ST_HEAD: begin
        if (!list_val) begin
          state_nxt = ST_POP;
        end else begin
          edge_addr   = head_val;
          edge_nxt    = head_val;
          tail_nxt    = tail_val;
          ctl.edge_rd = 1'b1;
          state_nxt   = ST_DEG_RD;
        end
      end
      ST_DEG_RD: begin
        deg_addr   = cons_val;
        ctl.deg_rd = 1'b1;
        state_nxt  = ST_DEG_UPD;
      end
      ST_DEG_UPD: begin
        deg_addr = cons_val;
        deg_inc  = 1'b0;
        if (deg_val != '0) begin
          ctl.deg_wr = 1'b1;
          // Count reaches zero here: queue the consumer if it is in range
          if ((deg_val == DW'(1)) && (32'(cons_val) < 32'(n_r))) begin
            fifo_push      = 1'b1;
            fifo_push_data = AW'(cons_val);
          end
        end
        // The list ends at the producer's tail entry
        if (edge_r == tail_r) begin
          state_nxt = ST_POP;
        end else begin
          edge_addr   = next_val;
          edge_nxt    = next_val;
          ctl.edge_rd = 1'b1;
          state_nxt   = ST_DEG_RD;
        end
      end
      ST_DONE: begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.order_node    = pend_v_r ? NODE_W'(pend_node_r) : '0;
        out_item_nxt.has_node      = pend_v_r;
        out_item_nxt.last          = 1'b1;
        out_item_nxt.incomplete    = (emit_cnt_r < n_r);
        out_item_nxt.edge_overflow = ovf_r;
        // Drop the graph for the next load
        ctl.clear  = 1'b1;
        fifo_clear = 1'b1;
        ovf_nxt    = 1'b0;
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers: no reset needed
  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    cons_r      <= cons_nxt;
    n_r         <= n_nxt;
    scan_r      <= scan_nxt;
    emit_cnt_r  <= emit_cnt_nxt;
    edge_r      <= edge_nxt;
    tail_r      <= tail_nxt;
    pend_node_r <= pend_node_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> (state_r == ST_IDLE))
    else $error("final result shown while the run is still active");

  a_idle_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> fifo_empty)
    else $error("ready queue not empty between runs");

  a_empty_order_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.has_node) |-> (out_item.last && (out_item.order_node == '0)))
    else $error("empty-order result is not the final one");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for topological_sort_kahn_top: edge loads and sort runs.
// A scoreboard class predicts each run's node order; depends on kts_pkg.

// Predicts Kahn's order from the edges seen so far and checks each result
class topo_order_board;
  bit [6:0]                   indegree [kts_pkg::KTS_MAX_NODES];
  bit [kts_pkg::NODE_W-1:0]   edge_src [kts_pkg::KTS_MAX_EDGES];
  bit [kts_pkg::NODE_W-1:0]   edge_dst [kts_pkg::KTS_MAX_EDGES];
  int unsigned                edge_count;
  bit                         lost_edge;
  kts_pkg::kts_out_t          order_q [$];
  int unsigned                errors;

  function new();
    errors = 0;
    wipe_graph();
  endfunction

  function void wipe_graph();
    foreach (indegree[i]) indegree[i] = '0;
    edge_count = 0;
    lost_edge  = 1'b0;
  endfunction

  function int unsigned pending();
    return order_q.size();
  endfunction

  // Stored edges in arrival order; walking them filtered by source keeps
  // each producer's list in insertion order.
  function void predict_order(bit [kts_pkg::TOTAL_W-1:0] total);
    bit [kts_pkg::NODE_W-1:0] ready [kts_pkg::KTS_MAX_NODES];
    int unsigned              limit, rd, wr, emitted;
    bit [kts_pkg::NODE_W-1:0] cur, dst;
    kts_pkg::kts_out_t        r;
    limit = 32'(total);
    if (limit > kts_pkg::KTS_MAX_NODES) limit = kts_pkg::KTS_MAX_NODES;
    if (limit > kts_pkg::RESULT_CAP) limit = kts_pkg::RESULT_CAP;
    rd = 0;
    wr = 0;
    emitted = 0;
    for (int i = 0; i < limit; i++) begin
      if (indegree[i] == 0) begin
        ready[wr] = i[kts_pkg::NODE_W-1:0];
        wr++;
      end
    end
    while (rd < wr) begin
      cur = ready[rd];
      rd++;
      r = '0;
      r.order_node = cur;
      r.has_node   = 1'b1;
      order_q = {order_q, r};
      emitted++;
      for (int e = 0; e < edge_count; e++) begin
        if (edge_src[e] == cur) begin
          dst = edge_dst[e];
          if (indegree[dst] != 0) begin
            indegree[dst]--;
            if (indegree[dst] == 0 && dst < limit && wr < kts_pkg::KTS_MAX_NODES) begin
              ready[wr] = dst;
              wr++;
            end
          end
        end
      end
    end
    if (emitted == 0) begin
      r = '0;
      r.incomplete = (limit != 0);
    end else begin
      r = order_q.pop_back();
      r.incomplete = (emitted < limit);
    end
    r.last          = 1'b1;
    r.edge_overflow = lost_edge;
    order_q = {order_q, r};
    wipe_graph();
  endfunction

  function void note_item(kts_pkg::kts_in_t it);
    if (it.command == kts_pkg::CMD_ADD_EDGE) begin
      // 5-bit endpoints always fall inside the node range
      if (edge_count >= kts_pkg::KTS_MAX_EDGES) begin
        lost_edge = 1'b1;
      end else begin
        edge_src[edge_count] = it.producer_node;
        edge_dst[edge_count] = it.consumer_node;
        edge_count++;
        indegree[it.consumer_node]++;
      end
    end else begin
      predict_order(it.node_total);
    end
  endfunction

  function void check_result(kts_pkg::kts_out_t got);
    kts_pkg::kts_out_t want;
    if (order_q.size() == 0) begin
      if (errors < 10)
        $display("unexpected result: node %0d has %0b last %0b inc %0b ovf %0b",
                 got.order_node, got.has_node, got.last, got.incomplete, got.edge_overflow);
      errors++;
      return;
    end
    want = order_q.pop_front();
    if (got.order_node !== want.order_node || got.has_node !== want.has_node ||
        got.last !== want.last || got.incomplete !== want.incomplete ||
        got.edge_overflow !== want.edge_overflow) begin
      if (errors < 10)
        $display("mismatch node/has/last/inc/ovf: want %0d/%0b/%0b/%0b/%0b got %0d/%0b/%0b/%0b/%0b",
                 want.order_node, want.has_node, want.last, want.incomplete,
                 want.edge_overflow, got.order_node, got.has_node, got.last,
                 got.incomplete, got.edge_overflow);
      errors++;
    end
  endfunction
endclass

module testbench import kts_pkg::*; ();

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  kts_in_t  in_item;
  logic     out_valid;
  kts_out_t out_item;

  topo_order_board sb;
  int unsigned     items_sent;

  topological_sort_kahn_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check results before noting a new item: a run accepted on the same edge
  // as an older result must not queue ahead of it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_item(in_item);
    end
  end

  // Drive one item at the falling edge and hold it until the block takes it.
  // Start stays high so back-to-back items need no gap.
  task automatic send_item(input kts_in_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_edge(input int unsigned src, input int unsigned dst);
    kts_in_t     it;
    int unsigned junk;
    junk = $urandom;
    it = '0;
    it.command       = CMD_ADD_EDGE;
    it.producer_node = src[NODE_W-1:0];
    it.consumer_node = dst[NODE_W-1:0];
    it.node_total    = junk[TOTAL_W-1:0];  // ignored on an edge load
    send_item(it);
  endtask

  task automatic send_run(input int unsigned total);
    kts_in_t     it;
    int unsigned junk;
    junk = $urandom;
    it = '0;
    it.command       = CMD_RUN;
    it.producer_node = junk[NODE_W-1:0];  // ignored on a run
    it.consumer_node = junk[2*NODE_W-1:NODE_W];
    it.node_total    = total[TOTAL_W-1:0];
    send_item(it);
  endtask

  // Sometimes drop start for a random gap with junk on the item bus
  task automatic maybe_idle(input int unsigned idle_pct);
    int unsigned gap, junk;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap  = $urandom_range(1, 6);
      junk = $urandom;
      @(negedge clk);
      start   <= 1'b0;
      in_item <= junk[$bits(kts_in_t)-1:0];
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the sender off until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One graph with random content, closed by a run. Mostly small graphs;
  // half of them forward-only so the sort gets deep, the rest may hold cycles.
  task automatic random_graph(input int unsigned idle_pct, input bit overfill);
    int unsigned span, n_edges, a, b, tmp;
    bit          forward;
    span    = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 12);
    forward = $urandom_range(0, 1);
    n_edges = overfill ? $urandom_range(65, 70) : $urandom_range(0, span + span / 2);
    for (int k = 0; k < n_edges; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 31);
        b = $urandom_range(0, 31);
      end else begin
        a = $urandom_range(0, span - 1);
        b = $urandom_range(0, span - 1);
      end
      if (forward && a > b) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
      maybe_idle(idle_pct);
      send_edge(a, b);
    end
    maybe_idle(idle_pct);
    send_run(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : span);
  endtask

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned idle_pct [3];
    int unsigned phase_start;
    sb         = new();
    items_sent = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty graph, saturated count, then a graph with a
    // self loop, a cycle, a duplicate edge and nodes past the count
    send_run(0);
    send_run(63);
    send_edge(31, 0);
    send_edge(0, 31);
    send_edge(5, 5);
    send_edge(3, 4);
    send_edge(3, 4);
    send_edge(4, 6);
    send_edge(6, 3);
    send_edge(1, 2);
    send_edge(2, 7);
    send_run(8);
    send_edge(1, 0);
    send_run(1);
    send_edge(0, 1);
    send_edge(30, 31);
    send_run(32);
    drain_results();

    // Random phases: no idling, sender idle 60 percent, sender idle 25 percent
    idle_pct[0] = 0;
    idle_pct[1] = 60;
    idle_pct[2] = 25;
    for (int p = 0; p < 3; p++) begin
      phase_start = items_sent;
      random_graph(idle_pct[p], p == 1);
      while (items_sent - phase_start < 50) random_graph(idle_pct[p], 1'b0);
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/kts_pkg.sv
hw/rtl/kts_store.sv
hw/rtl/kts_fifo.sv
hw/rtl/topological_sort_kahn_top.sv
sim/testbench.sv
